// File: rtl/lru_write_back_sector_cache_control_unit_defines.svh
// Assertion macros shared by the cache control RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef LRU_WRITE_BACK_SECTOR_CACHE_CONTROL_UNIT_DEFINES_SVH
`define LRU_WRITE_BACK_SECTOR_CACHE_CONTROL_UNIT_DEFINES_SVH

// same-cycle implication
`define LRUSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LRUSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lrusc_pkg.sv
// Shared types and constants of the sector cache control unit.
// Depends on nothing.
package lrusc_pkg;

  localparam int LINES_DEF = 64;
  localparam int IDX_W     = 8;
  localparam int SECTOR_W  = 32;
  localparam int TIME_W    = 31;
  localparam int FUNC_W    = 2;
  localparam int IN_W      = 72;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  // token that walks the row of line cells
  typedef struct packed {
    logic                vld;
    logic                flush;
    logic                wr;
    logic [IDX_W-1:0]    idx;
    logic [SECTOR_W-1:0] sector;
    logic [TIME_W-1:0]   tm;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic                hit_dirty;
    logic                inv;
    logic [IDX_W-1:0]    inv_idx;
    logic                have_min;
    logic [TIME_W-1:0]   min_time;
    logic [IDX_W-1:0]    min_idx;
    logic                min_dirty;
    logic [SECTOR_W-1:0] min_sector;
    logic                wb;
    logic [SECTOR_W-1:0] vs;
  } tok_t;

  // line update broadcast to all cells
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic                dirty;
    logic [SECTOR_W-1:0] sector;
    logic [TIME_W-1:0]   tm;
  } upd_t;

endpackage

// File: rtl/lrusc_cell.sv
// One cache line cell: holds valid, dirty, sector and time of its line.
// Updates the passing token and hands it on. Depends on lrusc_pkg.
module lrusc_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  lrusc_pkg::tok_t tok_in,
  input  lrusc_pkg::upd_t upd,
  output lrusc_pkg::tok_t tok_out
);

  localparam logic [lrusc_pkg::IDX_W-1:0] MY_IDX = IDX[lrusc_pkg::IDX_W-1:0];

  logic                          valid;
  logic                          dirty;
  logic [lrusc_pkg::SECTOR_W-1:0] sector;
  logic [lrusc_pkg::TIME_W-1:0]   tm;
  lrusc_pkg::tok_t               tok_next;
  logic                          flush_here;

  assign flush_here = tok_in.vld && tok_in.flush && (tok_in.idx == MY_IDX);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.vld && !tok_in.flush) begin
      if (valid && (sector == tok_in.sector) && !tok_in.hit) begin
        tok_next.hit       = 1'b1;
        tok_next.hit_idx   = MY_IDX;
        tok_next.hit_dirty = dirty;
      end
      if (!valid && !tok_in.inv) begin
        tok_next.inv     = 1'b1;
        tok_next.inv_idx = MY_IDX;
      end
      if (!tok_in.have_min || (tm < tok_in.min_time)) begin
        tok_next.have_min   = 1'b1;
        tok_next.min_time   = tm;
        tok_next.min_idx    = MY_IDX;
        tok_next.min_dirty  = dirty;
        tok_next.min_sector = sector;
      end
    end else if (flush_here) begin
      tok_next.wb = valid && dirty;
      tok_next.vs = (valid && dirty) ? sector : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      tm    <= '0;
    end else begin
      if (en && flush_here) begin
        valid <= 1'b0;
        dirty <= 1'b0;
      end
      if (upd.en && (upd.idx == MY_IDX)) begin
        valid <= 1'b1;
        dirty <= upd.dirty;
        tm    <= upd.tm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && (upd.idx == MY_IDX)) begin
      sector <= upd.sector;
    end
  end

endmodule

// File: rtl/lru_write_back_sector_cache_control_unit.sv
// Top level of the LRU write-back sector cache control unit.
// Depends on lrusc_pkg, lrusc_cell and the assertion macro header.
//
//  channel  dir  item
//  in       in   func, sector, access_time (one request)
//  out      out  line, hit, fetch, writeback, victim_sector; tlast = last
//
// Each item walks the cell row one cell per cycle while the output is not stalled; a read
// or write result passes the source register, every cell and the output register. Flush
// results follow one per cycle while the output is not stalled. in_tready drops at accept
// and rises after the last result registers; func 3 is accepted and dropped with no result.
// Synchronous reset clears all lines. A stalled output freezes the whole row.
`include "lru_write_back_sector_cache_control_unit_defines.svh"

module lru_write_back_sector_cache_control_unit #(
  parameter int  LINES = lrusc_pkg::LINES_DEF,
  localparam int IW    = $clog2(LINES),
  localparam int OUT_W = ((IW + 35 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // func[1:0], sector[33:2], access_time[64:34]
  input  logic [lrusc_pkg::IN_W-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // line, hit, fetch, writeback, victim_sector
  output logic [OUT_W-1:0]          out_tdata,
  output logic                      out_tlast
);

  localparam int LAST = LINES - 1;

  logic [lrusc_pkg::FUNC_W-1:0]   func;
  logic [lrusc_pkg::SECTOR_W-1:0] in_sector;
  logic [lrusc_pkg::TIME_W-1:0]   in_time;
  logic                           en;
  logic                           acc;
  logic                           busy;
  logic                           fl_active;
  logic [IW-1:0]                  fl_cnt;
  lrusc_pkg::tok_t                src;
  lrusc_pkg::tok_t                src_next;
  lrusc_pkg::tok_t                link [0:LINES];
  lrusc_pkg::tok_t                tok;
  lrusc_pkg::upd_t                upd;
  logic                           ex;
  logic [lrusc_pkg::IDX_W-1:0]    ex_line;
  logic                           ex_hit;
  logic                           ex_fetch;
  logic                           ex_wb;
  logic [lrusc_pkg::SECTOR_W-1:0] ex_vs;
  logic                           ex_last;
  logic [IW-1:0]                  o_line;
  logic                           o_hit;
  logic                           o_fetch;
  logic                           o_wb;
  logic [lrusc_pkg::SECTOR_W-1:0] o_vs;

  assign func      = in_tdata[1:0];
  assign in_sector = in_tdata[33:2];
  assign in_time   = in_tdata[64:34];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = !busy;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    src_next = src;
    if (en) begin
      src_next.vld = 1'b0;
    end
    if (fl_active && en) begin
      src_next       = '0;
      src_next.vld   = 1'b1;
      src_next.flush = 1'b1;
      src_next.idx   = lrusc_pkg::IDX_W'(fl_cnt);
    end
    if (acc && ((func == lrusc_pkg::FUNC_READ) || (func == lrusc_pkg::FUNC_WRITE))) begin
      src_next        = '0;
      src_next.vld    = 1'b1;
      src_next.wr     = (func == lrusc_pkg::FUNC_WRITE);
      src_next.sector = in_sector;
      src_next.tm     = in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src       <= '0;
      busy      <= 1'b0;
      fl_active <= 1'b0;
      fl_cnt    <= '0;
    end else begin
      src <= src_next;
      if (acc && ((func == lrusc_pkg::FUNC_READ) || (func == lrusc_pkg::FUNC_WRITE)
                  || (func == lrusc_pkg::FUNC_FLUSH))) begin
        busy <= 1'b1;
      end else if (ex && ex_last) begin
        busy <= 1'b0;
      end
      if (acc && (func == lrusc_pkg::FUNC_FLUSH)) begin
        fl_active <= 1'b1;
        fl_cnt    <= '0;
      end else if (fl_active && en) begin
        fl_cnt <= fl_cnt + 1'b1;
        if (fl_cnt == LAST[IW-1:0]) begin
          fl_active <= 1'b0;
        end
      end
    end
  end

  assign link[0] = src;

  for (genvar g = 0; g < LINES; g++) begin : g_cell
    lrusc_cell #(
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .tok_in (link[g]),
      .upd    (upd),
      .tok_out(link[g+1])
    );
  end

  assign tok = link[LINES];
  assign ex  = tok.vld && en;

  always_comb begin
    ex_line    = tok.idx;
    ex_hit     = 1'b0;
    ex_fetch   = 1'b0;
    ex_wb      = tok.wb;
    ex_vs      = tok.vs;
    ex_last    = (tok.idx == LAST[lrusc_pkg::IDX_W-1:0]);
    upd        = '0;
    upd.sector = tok.sector;
    upd.tm     = tok.tm;
    if (!tok.flush) begin
      ex_last = 1'b1;
      if (tok.hit) begin
        ex_line   = tok.hit_idx;
        ex_hit    = 1'b1;
        ex_wb     = 1'b0;
        ex_vs     = '0;
        upd.dirty = tok.wr || tok.hit_dirty;
      end else if (tok.inv) begin
        ex_line   = tok.inv_idx;
        ex_fetch  = 1'b1;
        ex_wb     = 1'b0;
        ex_vs     = '0;
        upd.dirty = tok.wr;
      end else begin
        ex_line   = tok.min_idx;
        ex_fetch  = 1'b1;
        ex_wb     = tok.min_dirty;
        ex_vs     = tok.min_dirty ? tok.min_sector : '0;
        upd.dirty = tok.wr;
      end
      upd.en  = ex;
      upd.idx = ex_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= tok.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ex) begin
      o_line    <= ex_line[IW-1:0];
      o_hit     <= ex_hit;
      o_fetch   <= ex_fetch;
      o_wb      <= ex_wb;
      o_vs      <= ex_vs;
      out_tlast <= ex_last;
    end
  end

  assign out_tdata = OUT_W'({o_vs, o_wb, o_fetch, o_hit, o_line});

  `LRUSC_ASSERT_NOW(a_ready_idle, in_tready, !src.vld && !fl_active, "ready while a request is in flight")
  `LRUSC_ASSERT_NOW(a_flush_busy, fl_active, busy, "flush tokens issued while not busy")
  `LRUSC_ASSERT_NEXT(a_last_frees, ex && ex_last, !busy, "busy kept after last result")
  `LRUSC_ASSERT_NOW(a_hit_no_fetch, ex && !tok.flush, ex_hit != ex_fetch, "access result neither hit nor fetch")

endmodule
